// File: src/lted_pkg.sv
// ----------------------------------------------------------------------------
// lted_pkg
// Shared types, constants and lookup functions for the text date converter.
// ----------------------------------------------------------------------------
`default_nettype none

package lted_pkg;

    // result status codes
    localparam logic [1:0] ST_VALID   = 2'd0;
    localparam logic [1:0] ST_MISSING = 2'd1;
    localparam logic [1:0] ST_RANGE   = 2'd2;

    localparam logic [13:0] DIGIT_MAX  = 14'd16383;
    localparam logic [2:0]  LEN_SAT    = 3'd5;
    localparam logic [2:0]  PREFIX_LEN = 3'd3;
    localparam logic [2:0]  YEAR_LEN   = 3'd4;
    localparam logic [13:0] DAY_MAX    = 14'd31;

    localparam int unsigned YEAR_MIN      = 1970;
    localparam int unsigned YEAR_MAX      = 3000;
    localparam int unsigned DAYS_PER_YEAR = 365;
    localparam int unsigned SEC_PER_DAY   = 86400;
    // leap days in 1..1969
    localparam int unsigned LEAPS_1969    = 477;
    // x / 100 == (x * RECIP100) >> RECIP_SHIFT for x below 4096
    localparam int unsigned RECIP100      = 5243;
    localparam int unsigned RECIP_SHIFT   = 19;

    localparam int unsigned SEC_W  = 36;
    localparam int unsigned DAYS_W = 19;

    typedef struct packed {
        logic [3:0]  month;
        logic [4:0]  day;
        logic [13:0] year;
    } t_fields;

    // month number 1..12 for a lower-cased three-letter prefix, 0 for none
    function automatic logic [3:0] month_code(input logic [23:0] p);
        logic [3:0] m;
        case (p)
            "jan":   m = 4'd1;
            "feb":   m = 4'd2;
            "mar":   m = 4'd3;
            "apr":   m = 4'd4;
            "may":   m = 4'd5;
            "jun":   m = 4'd6;
            "jul":   m = 4'd7;
            "aug":   m = 4'd8;
            "sep":   m = 4'd9;
            "oct":   m = 4'd10;
            "nov":   m = 4'd11;
            "dec":   m = 4'd12;
            default: m = 4'd0;
        endcase
        return m;
    endfunction

    // days before the first of month m in a common year
    function automatic logic [8:0] days_before(input logic [3:0] m);
        logic [8:0] d;
        case (m)
            4'd2:    d = 9'd31;
            4'd3:    d = 9'd59;
            4'd4:    d = 9'd90;
            4'd5:    d = 9'd120;
            4'd6:    d = 9'd151;
            4'd7:    d = 9'd181;
            4'd8:    d = 9'd212;
            4'd9:    d = 9'd243;
            4'd10:   d = 9'd273;
            4'd11:   d = 9'd304;
            4'd12:   d = 9'd334;
            default: d = 9'd0;
        endcase
        return d;
    endfunction

endpackage

`default_nettype wire

// File: src/lted_if.sv
// ----------------------------------------------------------------------------
// lted_in_if / lted_out_if
// Valid/ready channels for text bytes in and converted dates out.
// ----------------------------------------------------------------------------
`default_nettype none

interface lted_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] char_code;
    logic       last_char;

    modport source (output valid, output char_code, output last_char, input ready);
    modport sink   (input valid, input char_code, input last_char, output ready);
endinterface

interface lted_out_if;
    logic               valid;
    logic               ready;
    logic signed [35:0] time_seconds;
    logic [1:0]         status;

    modport source (output valid, output time_seconds, output status, input ready);
    modport sink   (input valid, input time_seconds, input status, output ready);
endinterface

`default_nettype wire

// File: src/lted_token.sv
// ----------------------------------------------------------------------------
// lted_token
// Byte tokenizer: keeps the current token and the month, day and year seen
// so far; presents the flushed fields for the final byte.
// ----------------------------------------------------------------------------
`default_nettype none

module lted_token (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_accept,
    input  wire logic [7:0]       i_char_code,
    input  wire logic             i_last_char,
    output lted_pkg::t_fields     o_fields
);

    logic [3:0]  r_month, n_month;
    logic [4:0]  r_day, n_day;
    logic [13:0] r_year, n_year;
    logic [2:0]  r_len, n_len;
    logic        r_starts, n_starts;
    logic [7:0]  r_pfx0, r_pfx1, r_pfx2, n_pfx0, n_pfx1, n_pfx2;
    logic [13:0] r_dv, n_dv;
    logic        r_ended, n_ended;

    logic        is_dig, is_let, is_aln, do_end;
    logic [2:0]  a_len, e_len;
    logic        a_starts, e_starts;
    logic [7:0]  a_pfx0, a_pfx1, a_pfx2, e_pfx0, e_pfx1, e_pfx2;
    logic [13:0] a_dv, e_dv;
    logic        a_ended;
    logic [17:0] dv_x10;
    logic [3:0]  mcode;

    always_comb begin
        is_dig = (i_char_code >= 8'h30) && (i_char_code <= 8'h39);
        is_let = ((i_char_code >= 8'h41) && (i_char_code <= 8'h5A))
              || ((i_char_code >= 8'h61) && (i_char_code <= 8'h7A));
        is_aln = is_dig || is_let;

        // token with this byte appended
        a_starts = (r_len == 3'd0) ? is_let : r_starts;
        a_pfx0   = (r_len == 3'd0) ? i_char_code : r_pfx0;
        a_pfx1   = (r_len == 3'd1) ? i_char_code : r_pfx1;
        a_pfx2   = (r_len == 3'd2) ? i_char_code : r_pfx2;
        a_dv     = r_dv;
        a_ended  = r_ended;
        dv_x10   = (18'(r_dv) << 3) + (18'(r_dv) << 1) + 18'(i_char_code[3:0]);
        if (!a_starts && !r_ended) begin
            if (is_dig) begin
                a_dv = (dv_x10 > 18'(lted_pkg::DIGIT_MAX)) ? lted_pkg::DIGIT_MAX
                                                           : dv_x10[13:0];
            end else begin
                a_ended = 1'b1;
            end
        end
        a_len = (r_len < lted_pkg::LEN_SAT) ? r_len + 3'd1 : r_len;

        // token that a separator or the final byte closes
        e_len    = is_aln ? a_len    : r_len;
        e_starts = is_aln ? a_starts : r_starts;
        e_pfx0   = is_aln ? a_pfx0   : r_pfx0;
        e_pfx1   = is_aln ? a_pfx1   : r_pfx1;
        e_pfx2   = is_aln ? a_pfx2   : r_pfx2;
        e_dv     = is_aln ? a_dv     : r_dv;
        do_end   = !is_aln || i_last_char;

        mcode = lted_pkg::month_code({e_pfx0 | 8'h20, e_pfx1 | 8'h20, e_pfx2 | 8'h20});

        n_month = r_month;
        n_day   = r_day;
        n_year  = r_year;
        if (do_end && (e_len != 3'd0)) begin
            if (e_starts) begin
                if ((e_len >= lted_pkg::PREFIX_LEN) && (mcode != 4'd0)) begin
                    n_month = mcode;
                end
            end else if (e_len == lted_pkg::YEAR_LEN) begin
                n_year = e_dv;
            end else if ((e_dv >= 14'd1) && (e_dv <= lted_pkg::DAY_MAX)) begin
                n_day = e_dv[4:0];
            end
        end

        if (do_end) begin
            n_len    = 3'd0;
            n_starts = 1'b0;
            n_pfx0   = 8'd0;
            n_pfx1   = 8'd0;
            n_pfx2   = 8'd0;
            n_dv     = 14'd0;
            n_ended  = 1'b0;
        end else begin
            n_len    = a_len;
            n_starts = a_starts;
            n_pfx0   = a_pfx0;
            n_pfx1   = a_pfx1;
            n_pfx2   = a_pfx2;
            n_dv     = a_dv;
            n_ended  = a_ended;
        end
    end

    assign o_fields = '{month: n_month, day: n_day, year: n_year};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n || (i_accept && i_last_char)) begin
            r_month  <= 4'd0;
            r_day    <= 5'd0;
            r_year   <= 14'd0;
            r_len    <= 3'd0;
            r_starts <= 1'b0;
            r_pfx0   <= 8'd0;
            r_pfx1   <= 8'd0;
            r_pfx2   <= 8'd0;
            r_dv     <= 14'd0;
            r_ended  <= 1'b0;
        end else if (i_accept) begin
            r_month  <= n_month;
            r_day    <= n_day;
            r_year   <= n_year;
            r_len    <= n_len;
            r_starts <= n_starts;
            r_pfx0   <= n_pfx0;
            r_pfx1   <= n_pfx1;
            r_pfx2   <= n_pfx2;
            r_dv     <= n_dv;
            r_ended  <= n_ended;
        end
    end

endmodule

`default_nettype wire

// File: src/lted_calc.sv
// ----------------------------------------------------------------------------
// lted_calc
// Four-stage pipeline from month/day/year to epoch seconds, with stalls
// that collapse bubbles; the last stage is the output register.
// ----------------------------------------------------------------------------
`default_nettype none

module lted_calc (
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    input  wire logic                 i_valid,
    input  wire lted_pkg::t_fields    i_fields,
    output logic                      o_ready,
    output logic                      o_valid,
    input  wire logic                 i_ready,
    output logic signed [35:0]        o_seconds,
    output logic [1:0]                o_status
);

    localparam int unsigned DW = lted_pkg::DAYS_W;
    localparam int unsigned SH = lted_pkg::RECIP_SHIFT;

    // stage 1: captured fields
    logic              r1_v;
    lted_pkg::t_fields r1_f;
    // stage 2: status and partial terms
    logic              r2_v;
    logic [1:0]        r2_status;
    logic [3:0]        r2_month;
    logic [4:0]        r2_day;
    logic [1:0]        r2_ylow;
    logic [DW-1:0]     r2_y365;
    logic [9:0]        r2_q4m;
    logic [4:0]        r2_q100y, r2_q100m;
    // stage 3: day count
    logic              r3_v;
    logic [1:0]        r3_status;
    logic [DW-1:0]     r3_days;
    // output
    logic              r_ov;
    logic [1:0]        r_ostatus;
    logic [35:0]       r_osec;

    logic out_adv, s3_adv, s2_adv, s1_adv;

    assign out_adv = !r_ov || i_ready;
    assign s3_adv  = !r3_v || out_adv;
    assign s2_adv  = !r2_v || s3_adv;
    assign s1_adv  = !r1_v || s2_adv;
    assign o_ready = s1_adv;

    // stage 1 -> 2
    logic [11:0] y12, ym1, yoff;
    logic [23:0] p_y, p_m;
    logic [1:0]  n2_status;

    always_comb begin
        y12  = r1_f.year[11:0];
        ym1  = y12 - 12'd1;
        yoff = y12 - 12'(lted_pkg::YEAR_MIN);
        p_y  = 24'(y12) * 24'(lted_pkg::RECIP100);
        p_m  = 24'(ym1) * 24'(lted_pkg::RECIP100);
        if ((r1_f.month == 4'd0) || (r1_f.day == 5'd0) || (r1_f.year == 14'd0)) begin
            n2_status = lted_pkg::ST_MISSING;
        end else if ((r1_f.year < 14'(lted_pkg::YEAR_MIN))
                  || (r1_f.year > 14'(lted_pkg::YEAR_MAX))
                  || (r1_f.month > 4'd12)) begin
            n2_status = lted_pkg::ST_RANGE;
        end else begin
            n2_status = lted_pkg::ST_VALID;
        end
    end

    // stage 2 -> 3
    logic          century, leap;
    logic [DW-1:0] leaps, n3_days;

    always_comb begin
        // a century year is where the hundreds count steps
        century = (r2_q100y != r2_q100m);
        leap    = century ? (r2_q100y[1:0] == 2'd0) : (r2_ylow == 2'd0);
        leaps   = DW'(r2_q4m) - DW'(r2_q100m) + DW'(r2_q100m[4:2])
                - DW'(lted_pkg::LEAPS_1969);
        n3_days = r2_y365 + leaps + DW'(lted_pkg::days_before(r2_month))
                + DW'((r2_month > 4'd2) && leap) + DW'(r2_day) - DW'(1);
    end

    // stage 3 -> out
    logic [35:0] n_sec;

    always_comb begin
        case (r3_status)
            lted_pkg::ST_VALID:   n_sec = 36'(r3_days) * 36'(lted_pkg::SEC_PER_DAY);
            lted_pkg::ST_MISSING: n_sec = 36'd0;
            default:              n_sec = '1;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r1_v <= 1'b0;
            r2_v <= 1'b0;
            r3_v <= 1'b0;
            r_ov <= 1'b0;
        end else begin
            if (s1_adv) begin
                r1_v <= i_valid;
            end
            if (s2_adv) begin
                r2_v <= r1_v;
            end
            if (s3_adv) begin
                r3_v <= r2_v;
            end
            if (out_adv) begin
                r_ov <= r3_v;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (s1_adv && i_valid) begin
            r1_f <= i_fields;
        end
        if (s2_adv && r1_v) begin
            r2_status <= n2_status;
            r2_month  <= r1_f.month;
            r2_day    <= r1_f.day;
            r2_ylow   <= y12[1:0];
            r2_y365   <= DW'(yoff) * DW'(lted_pkg::DAYS_PER_YEAR);
            r2_q4m    <= ym1[11:2];
            r2_q100y  <= p_y[SH +: 5];
            r2_q100m  <= p_m[SH +: 5];
        end
        if (s3_adv && r2_v) begin
            r3_status <= r2_status;
            r3_days   <= n3_days;
        end
        if (out_adv && r3_v) begin
            r_ostatus <= r3_status;
            r_osec    <= n_sec;
        end
    end

    assign o_valid   = r_ov;
    assign o_status  = r_ostatus;
    assign o_seconds = signed'(r_osec);

endmodule

`default_nettype wire

// File: src/loose_text_date_to_epoch_top.sv
// ----------------------------------------------------------------------------
// loose_text_date_to_epoch_top
// Free-text date to UTC midnight seconds since 1970, one byte per request.
//
//  channel  | dir | payload                          | notes
//  ---------+-----+----------------------------------+----------------------
//  i_req    | in  | char_code[7:0], last_char        | one byte per request
//  o_rsp    | out | time_seconds[35:0] s, status[1:0]| one per last_char
//
// One byte is taken every clock while the pipeline can accept it; the
// tokenizer updates in the cycle the byte is taken. A byte marked last
// enters a four-stage conversion pipeline ending in the output register.
// A stalled output fills the pipeline; input stalls only once all four
// stages hold results.
// Synchronous active-low reset clears all token state and the pipeline.
// ----------------------------------------------------------------------------
`default_nettype none

module loose_text_date_to_epoch_top (
    input  wire logic      i_clk,
    input  wire logic      i_rst_n,
    lted_in_if.sink        i_req,
    lted_out_if.source     o_rsp
);

    lted_pkg::t_fields fields;
    logic              accept;
    logic              calc_ready;
    logic              rsp_valid;
    logic signed [35:0] rsp_sec;
    logic [1:0]        rsp_status;

    assign i_req.ready = calc_ready;
    assign accept      = i_req.valid && calc_ready;

    lted_token u_token (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_accept    (accept),
        .i_char_code (i_req.char_code),
        .i_last_char (i_req.last_char),
        .o_fields    (fields)
    );

    lted_calc u_calc (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_valid   (accept && i_req.last_char),
        .i_fields  (fields),
        .o_ready   (calc_ready),
        .o_valid   (rsp_valid),
        .i_ready   (o_rsp.ready),
        .o_seconds (rsp_sec),
        .o_status  (rsp_status)
    );

    assign o_rsp.valid        = rsp_valid;
    assign o_rsp.time_seconds = rsp_sec;
    assign o_rsp.status       = rsp_status;

endmodule

`default_nettype wire

// File: src/lted_checker.sv
// ----------------------------------------------------------------------------
// lted_checker
// Port-level checks on the converted date responses.
// ----------------------------------------------------------------------------
`default_nettype none

module lted_checker (
    input wire logic               i_clk,
    input wire logic               i_rst_n,
    input wire logic               i_rsp_valid,
    input wire logic               i_rsp_ready,
    input wire logic signed [35:0] i_rsp_sec,
    input wire logic [1:0]         i_rsp_status
);

    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !i_rsp_valid)
        else $error("response valid right after reset");

    a_rsp_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_rsp_valid && !i_rsp_ready |=> i_rsp_valid && $stable(i_rsp_sec)
                                        && $stable(i_rsp_status))
        else $error("stalled response changed");

    a_status_code: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_rsp_valid |-> (i_rsp_status == lted_pkg::ST_VALID)
                     || (i_rsp_status == lted_pkg::ST_MISSING)
                     || (i_rsp_status == lted_pkg::ST_RANGE))
        else $error("undefined status");

    a_missing_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_rsp_valid && (i_rsp_status == lted_pkg::ST_MISSING) |-> i_rsp_sec == 36'sd0)
        else $error("missing field gives nonzero seconds");

    a_range_minus1: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_rsp_valid && (i_rsp_status != lted_pkg::ST_RANGE) |-> !i_rsp_sec[35])
        else $error("negative seconds on in-range result");

endmodule

bind loose_text_date_to_epoch_top lted_checker u_lted_checker (
    .i_clk        (i_clk),
    .i_rst_n      (i_rst_n),
    .i_rsp_valid  (o_rsp.valid),
    .i_rsp_ready  (o_rsp.ready),
    .i_rsp_sec    (o_rsp.time_seconds),
    .i_rsp_status (o_rsp.status)
);

`default_nettype wire
